>>> rtl/core/bcff_pkg.sv
// ----------------------------------------------------------------------------
// bcff_pkg
// Shared types and codes for the blob centroid flood fill block.
// ----------------------------------------------------------------------------
package bcff_pkg;

    localparam int COORD_W  = 10;
    localparam int GREY_W   = 8;
    localparam int OUT_W    = 18;
    localparam int STATUS_W = 2;
    localparam int MARK_W   = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY     = 2'd0,
        MARK_PROCESSED = 2'd1,
        MARK_OBJECT    = 2'd2
    } mark_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID     = 2'd0,
        STATUS_EDGE_SKIP = 2'd1,
        STATUS_ZERO_SUM  = 2'd2
    } status_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // column register update select
    typedef enum logic [2:0] {
        XS_HOLD,
        XS_INC,
        XS_DEC,
        XS_ORIG1,
        XS_START
    } xsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_RD,
        ST_START_EV,
        ST_LEFT_RD,
        ST_LEFT_EV,
        ST_RIGHT_CHK,
        ST_RIGHT_EV,
        ST_SEARCH_CHK,
        ST_SEARCH_EV,
        ST_NEXT_ROW,
        ST_DRAIN,
        ST_DIVX,
        ST_DIVX_WAIT,
        ST_DIVY,
        ST_DIVY_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  load_we;
        logic  q_init;
        xsel_t x_sel;
        logic  set_orig;
        logic  set_start;
        logic  set_end;
        logic  row_inc;
        logic  take;
        logic  div_start;
        logic  div_sel_y;
        logic  cap_x;
        logic  cap_y;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_load_ok;
        logic in_col_edge;
        logic in_row_out;
        logic mark_obj;
        logic mark_empty;
        logic x_zero;
        logic x_lt_end;
        logic x_lt_cols;
        logic y1_lt_rows;
        logic sum_zero;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/bcff_divider.sv
// ----------------------------------------------------------------------------
// bcff_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcff_divider #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb begin
        rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        quot_next = {quot_reg[NUM_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start) begin
                cnt_reg <= CNT_W'(NUM_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            den_reg  <= den;
            quot_reg <= num;
        end else if (cnt_reg != '0) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/core/bcff_datapath.sv
// ----------------------------------------------------------------------------
// bcff_datapath
// Image stores, fill coordinates, weighted sums, division and result register.
// ----------------------------------------------------------------------------
module bcff_datapath #(
    parameter int IMAGE_COLS = 1024,
    parameter int IMAGE_ROWS = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bcff_pkg::dp_cmd_t            cmd,
    output bcff_pkg::dp_stat_t           stat,
    input  logic                         s_operation,
    input  logic [bcff_pkg::COORD_W-1:0] s_pixel_col,
    input  logic [bcff_pkg::COORD_W-1:0] s_pixel_row,
    input  logic [bcff_pkg::GREY_W-1:0]  s_grey_value,
    input  logic                         s_is_object,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [bcff_pkg::OUT_W-1:0]   m_centroid_x_q8,
    output logic [bcff_pkg::OUT_W-1:0]   m_centroid_y_q8,
    output logic [bcff_pkg::STATUS_W-1:0] m_status
);

    localparam int DEPTH   = IMAGE_COLS * IMAGE_ROWS;
    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = $clog2(IMAGE_COLS + 1);
    localparam int YW      = $clog2(IMAGE_ROWS + 1);
    localparam int GW      = bcff_pkg::GREY_W;
    localparam int SUM_W   = GW + AW;
    localparam int CW_MAX  = (XW > YW) ? XW : YW;
    localparam int MOM_W   = SUM_W + CW_MAX;
    localparam int NUM_RAW = MOM_W + FRAC_BITS + 1;
    localparam int NUM_W   = (NUM_RAW > bcff_pkg::OUT_W) ? NUM_RAW : bcff_pkg::OUT_W + 1;
    localparam int OW      = bcff_pkg::OUT_W;

    logic [GW-1:0]               grey_mem [DEPTH];
    logic [bcff_pkg::MARK_W-1:0] mark_mem [DEPTH];

    logic [GW-1:0]               grey_rd_reg;
    logic [bcff_pkg::MARK_W-1:0] mark_rd_reg;

    logic [XW-1:0] x_reg, startx_reg, end_reg, orig_reg;
    logic [YW-1:0] y_reg;
    logic          skip_reg;

    logic [SUM_W-1:0] acc_sum_reg;
    logic [MOM_W-1:0] acc_x_reg, acc_y_reg;
    logic [XW+GW-1:0] prod_x_reg;
    logic [YW+GW-1:0] prod_y_reg;
    logic [GW-1:0]    prod_g_reg;
    logic             prod_valid_reg;

    logic [OW-1:0] cx_reg, cy_reg;
    logic          m_valid_reg;
    logic [OW-1:0] out_x_reg, out_y_reg;
    logic [bcff_pkg::STATUS_W-1:0] out_status_reg;

    logic [AW-1:0]    cur_addr, load_addr;
    logic [NUM_W-1:0] num_x, num_y, div_num, div_quot;
    logic [OW-1:0]    quot_sat;
    logic             div_done;

    assign cur_addr  = AW'(32'(y_reg) * IMAGE_COLS + 32'(x_reg));
    assign load_addr = AW'(32'(s_pixel_row) * IMAGE_COLS + 32'(s_pixel_col));

    // image stores: loads and processed marks share the write port
    always_ff @(posedge aclk) begin
        if (cmd.load_we) begin
            grey_mem[load_addr] <= s_grey_value;
            mark_mem[load_addr] <= s_is_object ? bcff_pkg::MARK_OBJECT : bcff_pkg::MARK_EMPTY;
        end else if (cmd.take) begin
            mark_mem[cur_addr] <= bcff_pkg::MARK_PROCESSED;
        end
        grey_rd_reg <= grey_mem[cur_addr];
        mark_rd_reg <= mark_mem[cur_addr];
    end

    // fill coordinates
    always_ff @(posedge aclk) begin
        if (cmd.q_init) begin
            x_reg      <= XW'(s_pixel_col);
            startx_reg <= XW'(s_pixel_col);
            end_reg    <= XW'(32'(s_pixel_col) + 2);
            y_reg      <= YW'(s_pixel_row);
            skip_reg   <= 32'(s_pixel_col) >= IMAGE_COLS - 1;
        end else begin
            unique case (cmd.x_sel)
                bcff_pkg::XS_HOLD:  x_reg <= x_reg;
                bcff_pkg::XS_INC:   x_reg <= x_reg + XW'(1);
                bcff_pkg::XS_DEC:   x_reg <= x_reg - XW'(1);
                bcff_pkg::XS_ORIG1: x_reg <= orig_reg + XW'(1);
                bcff_pkg::XS_START: x_reg <= startx_reg;
                default:            x_reg <= x_reg;
            endcase
            if (cmd.set_orig)  orig_reg   <= x_reg;
            if (cmd.set_start) startx_reg <= x_reg;
            if (cmd.set_end)   end_reg    <= x_reg;
            if (cmd.row_inc)   y_reg      <= y_reg + YW'(1);
        end
    end

    // products registered from the taken pixel, then summed into the accumulators
    always_ff @(posedge aclk) begin
        prod_x_reg <= x_reg * grey_rd_reg;
        prod_y_reg <= y_reg * grey_rd_reg;
        prod_g_reg <= grey_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            acc_sum_reg    <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
        end else begin
            prod_valid_reg <= cmd.take;
            if (cmd.q_init) begin
                acc_sum_reg <= '0;
                acc_x_reg   <= '0;
                acc_y_reg   <= '0;
            end else if (prod_valid_reg) begin
                acc_sum_reg <= acc_sum_reg + SUM_W'(prod_g_reg);
                acc_x_reg   <= acc_x_reg + MOM_W'(prod_x_reg);
                acc_y_reg   <= acc_y_reg + MOM_W'(prod_y_reg);
            end
        end
    end

    // rounded quotient: (moment * 2^F + sum/2) / sum
    assign num_x   = (NUM_W'(acc_x_reg) << FRAC_BITS) + NUM_W'(acc_sum_reg >> 1);
    assign num_y   = (NUM_W'(acc_y_reg) << FRAC_BITS) + NUM_W'(acc_sum_reg >> 1);
    assign div_num = cmd.div_sel_y ? num_y : num_x;

    bcff_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (acc_sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign quot_sat = (div_quot > NUM_W'(bcff_pkg::OUT_MAX)) ? bcff_pkg::OUT_MAX
                                                             : div_quot[OW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.cap_x) cx_reg <= quot_sat;
        if (cmd.cap_y) cy_reg <= quot_sat;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            priority if (skip_reg) begin
                out_x_reg      <= '0;
                out_y_reg      <= '0;
                out_status_reg <= bcff_pkg::STATUS_EDGE_SKIP;
            end else if (acc_sum_reg == '0) begin
                out_x_reg      <= '0;
                out_y_reg      <= '0;
                out_status_reg <= bcff_pkg::STATUS_ZERO_SUM;
            end else begin
                out_x_reg      <= cx_reg;
                out_y_reg      <= cy_reg;
                out_status_reg <= bcff_pkg::STATUS_VALID;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_centroid_x_q8 = out_x_reg;
    assign m_centroid_y_q8 = out_y_reg;
    assign m_status        = out_status_reg;

    always_comb begin
        stat.in_query    = s_operation == bcff_pkg::OP_QUERY;
        stat.in_load_ok  = (32'(s_pixel_col) < IMAGE_COLS) && (32'(s_pixel_row) < IMAGE_ROWS);
        stat.in_col_edge = 32'(s_pixel_col) >= IMAGE_COLS - 1;
        stat.in_row_out  = 32'(s_pixel_row) >= IMAGE_ROWS;
        stat.mark_obj    = mark_rd_reg == bcff_pkg::MARK_OBJECT;
        stat.mark_empty  = mark_rd_reg == bcff_pkg::MARK_EMPTY;
        stat.x_zero      = x_reg == '0;
        stat.x_lt_end    = x_reg < end_reg;
        stat.x_lt_cols   = 32'(x_reg) < IMAGE_COLS;
        stat.y1_lt_rows  = 32'(y_reg) + 1 < IMAGE_ROWS;
        stat.sum_zero    = acc_sum_reg == '0;
        stat.div_done    = div_done;
        stat.out_free    = !m_valid_reg || m_ready;
    end

    a_take_object: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> mark_rd_reg == bcff_pkg::MARK_OBJECT)
        else $error("pixel taken that is not an object");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg)
        else $error("result load did not raise valid");

    a_sum_moment: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_sum_reg == '0 |-> (acc_x_reg == '0 && acc_y_reg == '0))
        else $error("moment without intensity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

endmodule

>>> rtl/core/bcff_controller.sv
// ----------------------------------------------------------------------------
// bcff_controller
// Sequencer for loads, the row-by-row fill walk and the two divisions.
// ----------------------------------------------------------------------------
module bcff_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bcff_pkg::dp_stat_t stat,
    output bcff_pkg::dp_cmd_t  cmd
);

    bcff_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bcff_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bcff_pkg::ST_IDLE: begin
                if (s_valid && stat.in_query) begin
                    priority if (stat.in_col_edge) state_next = bcff_pkg::ST_FINISH;
                    else if (stat.in_row_out)      state_next = bcff_pkg::ST_DRAIN;
                    else                           state_next = bcff_pkg::ST_START_RD;
                end
            end
            bcff_pkg::ST_START_RD: state_next = bcff_pkg::ST_START_EV;
            bcff_pkg::ST_START_EV: begin
                priority if (!stat.mark_obj) state_next = bcff_pkg::ST_SEARCH_CHK;
                else if (stat.x_zero)        state_next = bcff_pkg::ST_RIGHT_CHK;
                else                         state_next = bcff_pkg::ST_LEFT_RD;
            end
            bcff_pkg::ST_LEFT_RD: state_next = bcff_pkg::ST_LEFT_EV;
            bcff_pkg::ST_LEFT_EV: begin
                if (stat.mark_obj && !stat.x_zero) state_next = bcff_pkg::ST_LEFT_RD;
                else                               state_next = bcff_pkg::ST_RIGHT_CHK;
            end
            bcff_pkg::ST_RIGHT_CHK: begin
                state_next = stat.x_lt_cols ? bcff_pkg::ST_RIGHT_EV : bcff_pkg::ST_NEXT_ROW;
            end
            bcff_pkg::ST_RIGHT_EV: begin
                state_next = stat.mark_obj ? bcff_pkg::ST_RIGHT_CHK : bcff_pkg::ST_NEXT_ROW;
            end
            bcff_pkg::ST_SEARCH_CHK: begin
                state_next = stat.x_lt_end ? bcff_pkg::ST_SEARCH_EV : bcff_pkg::ST_DRAIN;
            end
            bcff_pkg::ST_SEARCH_EV: begin
                priority if (stat.mark_empty) state_next = bcff_pkg::ST_SEARCH_CHK;
                else if (stat.mark_obj)       state_next = bcff_pkg::ST_RIGHT_CHK;
                else                          state_next = bcff_pkg::ST_NEXT_ROW;
            end
            bcff_pkg::ST_NEXT_ROW: begin
                state_next = stat.y1_lt_rows ? bcff_pkg::ST_START_RD : bcff_pkg::ST_DRAIN;
            end
            bcff_pkg::ST_DRAIN: state_next = bcff_pkg::ST_DIVX;
            bcff_pkg::ST_DIVX: begin
                state_next = stat.sum_zero ? bcff_pkg::ST_FINISH : bcff_pkg::ST_DIVX_WAIT;
            end
            bcff_pkg::ST_DIVX_WAIT: if (stat.div_done) state_next = bcff_pkg::ST_DIVY;
            bcff_pkg::ST_DIVY:      state_next = bcff_pkg::ST_DIVY_WAIT;
            bcff_pkg::ST_DIVY_WAIT: if (stat.div_done) state_next = bcff_pkg::ST_FINISH;
            bcff_pkg::ST_FINISH:    if (stat.out_free) state_next = bcff_pkg::ST_IDLE;
            default:                state_next = bcff_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            bcff_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.q_init  = stat.in_query;
                    cmd.load_we = !stat.in_query && stat.in_load_ok;
                end
            end
            bcff_pkg::ST_START_EV: begin
                if (stat.mark_obj) begin
                    cmd.take     = 1'b1;
                    cmd.set_orig = 1'b1;
                    cmd.x_sel    = stat.x_zero ? bcff_pkg::XS_INC : bcff_pkg::XS_DEC;
                end
            end
            bcff_pkg::ST_LEFT_EV: begin
                if (stat.mark_obj) begin
                    cmd.take      = 1'b1;
                    cmd.set_start = 1'b1;
                    cmd.x_sel     = stat.x_zero ? bcff_pkg::XS_ORIG1 : bcff_pkg::XS_DEC;
                end else begin
                    cmd.x_sel = bcff_pkg::XS_ORIG1;
                end
            end
            bcff_pkg::ST_RIGHT_CHK: cmd.set_end = !stat.x_lt_cols;
            bcff_pkg::ST_RIGHT_EV: begin
                if (stat.mark_obj) begin
                    cmd.take  = 1'b1;
                    cmd.x_sel = bcff_pkg::XS_INC;
                end else begin
                    cmd.set_end = 1'b1;
                end
            end
            bcff_pkg::ST_SEARCH_EV: begin
                priority if (stat.mark_empty) begin
                    cmd.x_sel = bcff_pkg::XS_INC;
                end else if (stat.mark_obj) begin
                    cmd.set_start = 1'b1;
                    cmd.take      = 1'b1;
                    cmd.x_sel     = bcff_pkg::XS_INC;
                end else begin
                    // processed pixel: fills nothing, range ends before it
                    cmd.set_start = 1'b1;
                    cmd.set_end   = 1'b1;
                end
            end
            bcff_pkg::ST_NEXT_ROW: begin
                if (stat.y1_lt_rows) begin
                    cmd.row_inc = 1'b1;
                    cmd.x_sel   = bcff_pkg::XS_START;
                end
            end
            bcff_pkg::ST_DIVX:      cmd.div_start = !stat.sum_zero;
            bcff_pkg::ST_DIVX_WAIT: cmd.cap_x = stat.div_done;
            bcff_pkg::ST_DIVY: begin
                cmd.div_start = 1'b1;
                cmd.div_sel_y = 1'b1;
            end
            bcff_pkg::ST_DIVY_WAIT: cmd.cap_y = stat.div_done;
            bcff_pkg::ST_FINISH:    cmd.out_load = stat.out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/blob_centroid_flood_fill.sv
// ----------------------------------------------------------------------------
// blob_centroid_flood_fill
// Grey image and mark map store with a scanline flood fill that returns the
// intensity-weighted centroid of the blob below a start pixel.
//
//   channel  dir  handshake          beat carries
//   s_       in   s_valid/s_ready    operation, pixel_col, pixel_row, grey, object
//   m_       out  m_valid/m_ready    centroid_x_q8, centroid_y_q8, status
//
// Loads stream at one per cycle while no query is in progress.
// A query walks the fill pixel by pixel and row by row, then, unless the sum is
// zero, runs two restoring divisions of one quotient bit per cycle (48 bits at the
// default size) over the single divider.
// The stores have no reset; reset clears the sequencer and the result valid.
// Input stalls for the whole query walk; the result register lets the next
// beat in while a result waits, and a query finishes only into a free slot.
// ----------------------------------------------------------------------------
module blob_centroid_flood_fill #(
    parameter int IMAGE_COLS = 1024,
    parameter int IMAGE_ROWS = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [bcff_pkg::COORD_W-1:0]  s_pixel_col,
    input  logic [bcff_pkg::COORD_W-1:0]  s_pixel_row,
    input  logic [bcff_pkg::GREY_W-1:0]   s_grey_value,
    input  logic                          s_is_object,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bcff_pkg::OUT_W-1:0]    m_centroid_x_q8,
    output logic [bcff_pkg::OUT_W-1:0]    m_centroid_y_q8,
    output logic [bcff_pkg::STATUS_W-1:0] m_status
);

    bcff_pkg::dp_cmd_t  cmd;
    bcff_pkg::dp_stat_t stat;

    bcff_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bcff_datapath #(
        .IMAGE_COLS (IMAGE_COLS),
        .IMAGE_ROWS (IMAGE_ROWS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_operation     (s_operation),
        .s_pixel_col     (s_pixel_col),
        .s_pixel_row     (s_pixel_row),
        .s_grey_value    (s_grey_value),
        .s_is_object     (s_is_object),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_centroid_x_q8 (m_centroid_x_q8),
        .m_centroid_y_q8 (m_centroid_y_q8),
        .m_status        (m_status)
    );

endmodule
